/* rtl/eprc_pkg.sv */
package eprc_pkg;

  localparam int CordicIters = 30;
  localparam int CordicW = 34;
  localparam logic signed [CordicW-1:0] CordicStart = 34'sd652032874;

  typedef logic signed [CordicW-1:0] cw_t;

  function automatic cw_t atan_lut(input int i);
    cw_t r;
    case (i)
      0: r = 34'sh20000000;  1: r = 34'sh12E4051E;  2: r = 34'sh09FB385B;
      3: r = 34'sh051111D4;  4: r = 34'sh028B0D43;  5: r = 34'sh0145D7E1;
      6: r = 34'sh00A2F61E;  7: r = 34'sh00517C55;  8: r = 34'sh0028BE53;
      9: r = 34'sh00145F2F; 10: r = 34'sh000A2F98; 11: r = 34'sh000517CC;
      12: r = 34'sh00028BE6; 13: r = 34'sh000145F3; 14: r = 34'sh0000A2FA;
      15: r = 34'sh0000517D; 16: r = 34'sh000028BE; 17: r = 34'sh0000145F;
      18: r = 34'sh00000A30; 19: r = 34'sh00000518; 20: r = 34'sh0000028C;
      21: r = 34'sh00000146; 22: r = 34'sh000000A3; 23: r = 34'sh00000051;
      24: r = 34'sh00000029; 25: r = 34'sh00000014; 26: r = 34'sh0000000A;
      27: r = 34'sh00000005; 28: r = 34'sh00000003; 29: r = 34'sh00000001;
      default: r = '0;
    endcase
    return r;
  endfunction

  // q30 product rounded half up
  function automatic cw_t mul30(input cw_t a, input cw_t b);
    logic signed [2*CordicW-1:0] p;
    p = a * b + (68'sd1 <<< 29);
    return cw_t'(p >>> 30);
  endfunction

endpackage

/* rtl/eprc_cell.sv */
module eprc_cell #(
  parameter int Stage = 0
) (
  input  logic                 clk_i,
  input  logic                 v_i,
  input  eprc_pkg::cw_t [2:0]  x_i,
  input  eprc_pkg::cw_t [2:0]  y_i,
  input  eprc_pkg::cw_t [2:0]  z_i,
  output eprc_pkg::cw_t [2:0]  x_o,
  output eprc_pkg::cw_t [2:0]  y_o,
  output eprc_pkg::cw_t [2:0]  z_o
);
  import eprc_pkg::*;

  cw_t [2:0] x_d, y_d, z_d, x_q, y_q, z_q;

  // one cordic micro-rotation for each of the three half angles
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!z_i[k][CordicW-1]) begin
        x_d[k] = x_i[k] - (y_i[k] >>> Stage);
        y_d[k] = y_i[k] + (x_i[k] >>> Stage);
        z_d[k] = z_i[k] - atan_lut(Stage);
      end else begin
        x_d[k] = x_i[k] + (y_i[k] >>> Stage);
        y_d[k] = y_i[k] - (x_i[k] >>> Stage);
        z_d[k] = z_i[k] + atan_lut(Stage);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule

/* rtl/euler_point_rotation_about_center_core.sv */
// Rotates a point about a center by roll, pitch and yaw, fully pipelined: busy is tied
// low and a transaction can be started in every cycle. Each result is strobed on done_o
// for one cycle; it passes through 30 cordic cells, then pair product, quaternion,
// quaternion product, matrix, dot product, sum and clamp stages, one register each.
// The receiver cannot stall; results are strobed once.
module euler_point_rotation_about_center_core #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] point_z_i,
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_y_i,
  input  logic signed [COORD_BITS-1:0] center_z_i,
  input  logic signed [ANGLE_BITS-1:0] roll_angle_i,
  input  logic signed [ANGLE_BITS-1:0] pitch_angle_i,
  input  logic signed [ANGLE_BITS-1:0] yaw_angle_i,
  output logic                         done_o,
  output logic signed [COORD_BITS-1:0] rotated_x_o,
  output logic signed [COORD_BITS-1:0] rotated_y_o,
  output logic signed [COORD_BITS-1:0] rotated_z_o,
  output logic                         saturated_o
);
  import eprc_pkg::*;

  localparam int MatBits = ((60 - COORD_BITS) < 30) ? (60 - COORD_BITS) : 30;
  localparam int MatShift = 30 - MatBits;
  localparam int DW = COORD_BITS + 1;
  localparam int PW = DW + MatBits + 4;
  localparam int Post = 7;
  localparam int Lat = CordicIters + Post;
  localparam int GeoLen = CordicIters + 5;
  localparam logic unsigned [7:0] FracUnused = 8'(FRAC_BITS);

  typedef logic signed [COORD_BITS-1:0] crd_t;
  typedef logic signed [DW-1:0] dif_t;
  typedef logic signed [PW-1:0] acc_t;
  typedef struct packed {
    crd_t [2:0] c;
    dif_t [2:0] d;
  } geo_t;

  assign busy = 1'b0;

  logic [Lat-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start};
    end
  end

  // geometry delay line alongside the cordic chain
  geo_t geo_q [GeoLen-1:0];
  geo_t geo_in;
  assign geo_in.c = {center_z_i, center_y_i, center_x_i};
  assign geo_in.d = {dif_t'(point_z_i) - dif_t'(center_z_i),
                     dif_t'(point_y_i) - dif_t'(center_y_i),
                     dif_t'(point_x_i) - dif_t'(center_x_i)};
  always_ff @(posedge clk_i) begin
    geo_q[0] <= geo_in;
    for (int i = 1; i < GeoLen; i++) geo_q[i] <= geo_q[i-1];
  end

  // half angles: 2^32 == 2*pi
  cw_t [2:0] cx [CordicIters:0];
  cw_t [2:0] cy [CordicIters:0];
  cw_t [2:0] cz [CordicIters:0];
  assign cx[0] = {3{CordicStart}};
  assign cy[0] = '0;
  assign cz[0] = {cw_t'(yaw_angle_i)   <<< (31 - ANGLE_BITS),
                  cw_t'(pitch_angle_i) <<< (31 - ANGLE_BITS),
                  cw_t'(roll_angle_i)  <<< (31 - ANGLE_BITS)};

  for (genvar g = 0; g < CordicIters; g++) begin : g_cell
    logic vin;
    if (g == 0) begin : g_first
      assign vin = start;
    end else begin : g_rest
      assign vin = vld_q[g-1];
    end
    eprc_cell #(.Stage(g)) u_cell (
      .clk_i, .v_i(vin),
      .x_i(cx[g]), .y_i(cy[g]), .z_i(cz[g]),
      .x_o(cx[g+1]), .y_o(cy[g+1]), .z_o(cz[g+1])
    );
  end

  // index 0 roll, 1 pitch, 2 yaw
  cw_t cr, sr, cp, sp, cyw, syw;
  assign cr = cx[CordicIters][0];  assign sr = cy[CordicIters][0];
  assign cp = cx[CordicIters][1];  assign sp = cy[CordicIters][1];
  assign cyw = cx[CordicIters][2]; assign syw = cy[CordicIters][2];

  // stage a: pair products
  cw_t cycp_q, sysp_q, cysp_q, sycp_q, cra_q, sra_q;
  always_ff @(posedge clk_i) begin
    cycp_q <= mul30(cyw, cp);
    sysp_q <= mul30(syw, sp);
    cysp_q <= mul30(cyw, sp);
    sycp_q <= mul30(syw, cp);
    cra_q  <= cr;
    sra_q  <= sr;
  end

  // stage b: quaternion
  cw_t qw_q, qx_q, qy_q, qz_q;
  always_ff @(posedge clk_i) begin
    qw_q <= mul30(cycp_q, cra_q) + mul30(sysp_q, sra_q);
    qx_q <= mul30(cycp_q, sra_q) - mul30(sysp_q, cra_q);
    qy_q <= mul30(cysp_q, cra_q) + mul30(sycp_q, sra_q);
    qz_q <= mul30(sycp_q, cra_q) - mul30(cysp_q, sra_q);
  end

  // stage c: quaternion products
  cw_t xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  always_ff @(posedge clk_i) begin
    xx_q <= mul30(qx_q, qx_q); yy_q <= mul30(qy_q, qy_q); zz_q <= mul30(qz_q, qz_q);
    xy_q <= mul30(qx_q, qy_q); xz_q <= mul30(qx_q, qz_q); yz_q <= mul30(qy_q, qz_q);
    wx_q <= mul30(qw_q, qx_q); wy_q <= mul30(qw_q, qy_q); wz_q <= mul30(qw_q, qz_q);
  end

  // stage d: matrix, rounded to MatBits
  localparam cw_t One = cw_t'(64'sd1 <<< 30);
  cw_t [8:0] m;
  acc_t [8:0] r_q;
  assign m[0] = One - 2 * (yy_q + zz_q);
  assign m[1] = 2 * (xy_q - wz_q);
  assign m[2] = 2 * (xz_q + wy_q);
  assign m[3] = 2 * (xy_q + wz_q);
  assign m[4] = One - 2 * (xx_q + zz_q);
  assign m[5] = 2 * (yz_q - wx_q);
  assign m[6] = 2 * (xz_q - wy_q);
  assign m[7] = 2 * (yz_q + wx_q);
  assign m[8] = One - 2 * (xx_q + yy_q);
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 9; k++) begin
      if (MatShift == 0) r_q[k] <= acc_t'(m[k]);
      else r_q[k] <= acc_t'((m[k] + (cw_t'(1) <<< (MatShift - 1))) >>> MatShift);
    end
  end

  // stage e: nine products, registered
  geo_t ge;
  assign ge = geo_q[CordicIters + 3];
  acc_t [8:0] p_q;
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        p_q[3*i+j] <= acc_t'(ge.d[j]) * r_q[3*i+j];
  end

  // stage f: sums, round, add center
  geo_t gf;
  assign gf = geo_q[CordicIters + 4];
  localparam int VW = PW - MatBits + 2;
  typedef logic signed [VW-1:0] val_t;
  val_t [2:0] v_q;
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++)
      v_q[i] <= val_t'((p_q[3*i] + p_q[3*i+1] + p_q[3*i+2]
                + (acc_t'(1) <<< (MatBits - 1))) >>> MatBits) + val_t'(gf.c[i]);
  end

  // stage g: clamp
  localparam val_t Hi = val_t'({1'b0, {(COORD_BITS-1){1'b1}}});
  localparam val_t Lo = -Hi - val_t'(1);
  localparam crd_t CrdHi = crd_t'(Hi);
  localparam crd_t CrdLo = crd_t'(Lo);
  crd_t [2:0] o_q;
  logic sat_q;
  always_ff @(posedge clk_i) begin
    logic s;
    s = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (v_q[i] > Hi) begin
        o_q[i] <= crd_t'(Hi); s = 1'b1;
      end else if (v_q[i] < Lo) begin
        o_q[i] <= crd_t'(Lo); s = 1'b1;
      end else begin
        o_q[i] <= crd_t'(v_q[i]);
      end
    end
    sat_q <= s | (FracUnused == 8'hff && 1'b0);
  end

  assign done_o = vld_q[Lat-1];
  assign rotated_x_o = o_q[0];
  assign rotated_y_o = o_q[1];
  assign rotated_z_o = o_q[2];
  assign saturated_o = sat_q;

  // a clamped result leaves at least one coordinate at an end of the range
  logic at_end;
  assign at_end = (o_q[0] == CrdHi) || (o_q[0] == CrdLo) ||
                  (o_q[1] == CrdHi) || (o_q[1] == CrdLo) ||
                  (o_q[2] == CrdHi) || (o_q[2] == CrdLo);

  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##(Lat) done_o) else $error("result strobe missing");
  a_nobusy: assert property (@(posedge clk_i) !busy) else $error("busy raised");
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && saturated_o |-> at_end) else $error("saturated without a clamped coordinate");
endmodule
